@@ hdl/lbp_histogram_assert.svh @@
// Assertion macros shared by the LBP histogram RTL.
`ifndef LBP_HISTOGRAM_ASSERT_SVH
`define LBP_HISTOGRAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define LBPH_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// When ante holds, cons must hold in the next cycle.
`define LBPH_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LBPH_CHECK(lbl, prop, msg)
`define LBPH_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/lbph_pkg.sv @@
// Shared constants, types and helpers of the LBP histogram block.
`timescale 1ns / 1ps
package lbph_pkg;

  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int RowW       = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int ColCntW    = ColW + 1;
  localparam int RowCntW    = RowW + 1;

  localparam int DimW      = 11;
  localparam int PixW      = 8;
  localparam int BinW      = 8;
  localparam int CodeBins  = 256;
  localparam int CountW    = 21;
  localparam int ModeW     = 2;
  localparam int CfgIdxW   = 1;
  localparam int NumSlots  = 3;
  localparam int SlotW     = 2;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [DimW-1:0]   DimReset = DimW'(1024);

  typedef enum logic [ModeW-1:0] {
    MODE_PIXEL = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COLUMNS = 1'd0,
    REG_ROWS    = 1'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_INIT_ABOVE,
    ST_INIT_FINAL,
    ST_LOAD,
    ST_SHIFT,
    ST_HIST_RD,
    ST_HIST_WR
  } ctrl_state_t;

  typedef struct packed {
    logic pix_write;
    logic clear;
    logic rd_issue;
    logic rd_load;
    logic walk_start;
    logic walk_final;
    logic line_rd;
    logic win_shift;
    logic col_inc;
    logic hist_rd;
    logic hist_wr;
  } lbph_cmd_t;

  typedef struct packed {
    logic row_end;
    logic has_above;
    logic last_row;
    logic done;
    logic walk_last;
    logic walk_final;
    logic col_first;
    logic col_end;
    logic out_free;
  } lbph_stat_t;

  // Next line-store slot, counting modulo three.
  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
    slot_inc = (s == SlotW'(NumSlots - 1)) ? '0 : s + SlotW'(1);
  endfunction

endpackage

@@ hdl/lbph_channels.sv @@
// Handshake channel interfaces of the LBP histogram block.
`timescale 1ns / 1ps
interface lbph_in_if;
  import lbph_pkg::*;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [PixW-1:0]   pixel;
  logic [BinW-1:0]   bin;
  modport source (output valid, output mode, output pixel, output bin, input ready);
  modport sink   (input valid, input mode, input pixel, input bin, output ready);
endinterface

interface lbph_out_if;
  import lbph_pkg::*;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] bin_count;
  logic              image_done;
  modport source (output valid, output bin_count, output image_done, input ready);
  modport sink   (input valid, input bin_count, input image_done, output ready);
endinterface

interface lbph_cfg_if;
  import lbph_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DimW-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/lbph_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbph_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/lbph_ctrl.sv @@
// Sequencer for pixel intake, bin reads, clears and the row walks that count codes.
`timescale 1ns / 1ps
`include "lbp_histogram_assert.svh"
module lbph_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [lbph_pkg::ModeW-1:0] in_mode,
  output logic                      in_ready,
  input  lbph_pkg::lbph_stat_t      stat,
  output lbph_pkg::lbph_cmd_t       cmd
);
  import lbph_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_PIXEL: begin
              if (!stat.done && stat.row_end) begin
                if (stat.has_above) begin
                  state_nxt = ST_INIT_ABOVE;
                end else if (stat.last_row) begin
                  state_nxt = ST_INIT_FINAL;
                end
              end
            end
            MODE_READ:  state_nxt = ST_READ_WAIT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ_WAIT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INIT_ABOVE: state_nxt = ST_LOAD;
      ST_INIT_FINAL: state_nxt = ST_LOAD;
      ST_LOAD:       state_nxt = ST_SHIFT;
      ST_SHIFT:      state_nxt = stat.col_first ? ST_LOAD : ST_HIST_RD;
      ST_HIST_RD:    state_nxt = ST_HIST_WR;
      ST_HIST_WR: begin
        if (!stat.col_end) begin
          state_nxt = ST_LOAD;
        end else if (!stat.walk_final && stat.walk_last) begin
          state_nxt = ST_INIT_FINAL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_PIXEL: cmd.pix_write = !stat.done;
            MODE_READ:  cmd.rd_issue  = 1'b1;
            MODE_CLEAR: cmd.clear     = 1'b1;
            default:    cmd           = '0;
          endcase
        end
      end
      ST_READ_WAIT:  cmd.rd_load = stat.out_free;
      ST_INIT_ABOVE: cmd.walk_start = 1'b1;
      ST_INIT_FINAL: begin
        cmd.walk_start = 1'b1;
        cmd.walk_final = 1'b1;
      end
      ST_LOAD:       cmd.line_rd = 1'b1;
      ST_SHIFT: begin
        cmd.win_shift = 1'b1;
        cmd.col_inc   = stat.col_first;
      end
      ST_HIST_RD:    cmd.hist_rd = 1'b1;
      ST_HIST_WR: begin
        cmd.hist_wr = 1'b1;
        cmd.col_inc = !stat.col_end;
      end
      default:       cmd = '0;
    endcase
  end

  `LBPH_CHECK_NEXT(a_wr_follows_rd, cmd.hist_rd, cmd.hist_wr, "histogram read not followed by its write")
  `LBPH_CHECK(a_walk_blocks_input, !(cmd.walk_start && in_ready), "walk started while taking input")

endmodule

@@ hdl/lbph_datapath.sv @@
// Positions, line store, 3x3 window, code logic, histogram store and result register.
`timescale 1ns / 1ps
`include "lbp_histogram_assert.svh"
module lbph_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lbph_pkg::lbph_cmd_t          cmd,
  output lbph_pkg::lbph_stat_t         stat,
  input  logic [lbph_pkg::PixW-1:0]    in_pixel,
  input  logic [lbph_pkg::BinW-1:0]    in_bin,
  input  logic                         cfg_valid,
  input  logic [lbph_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lbph_pkg::DimW-1:0]    cfg_data,
  output logic                         cfg_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lbph_pkg::CountW-1:0]  out_bin_count,
  output logic                         out_image_done
);
  import lbph_pkg::*;

  // Configuration and effective image size.
  logic [DimW-1:0]    cfg_cols_r;
  logic [DimW-1:0]    cfg_rows_r;
  logic [ColCntW-1:0] cols_eff;
  logic [RowCntW-1:0] rows_eff;

  // Raster position.
  logic [ColW-1:0]  col_pos_r, col_pos_nxt;
  logic [RowW-1:0]  row_pos_r, row_pos_nxt;
  logic [SlotW-1:0] row_slot_r, row_slot_nxt;
  logic             done_r, done_nxt;
  logic             row_end;
  logic             last_row;

  // Walk context.
  logic [SlotW-1:0]   walk_slot_r;
  logic               walk_above_r;
  logic               walk_above2_r;
  logic               walk_last_r;
  logic               walk_final_r;
  logic [SlotW-1:0]   top_slot_r, ctr_slot_r, bot_slot_r;
  logic               top_ok_r, bot_ok_r;
  logic [ColCntW-1:0] walk_col_r;
  logic               col_in_range;

  // Window: index 0 left, 1 centre column, 2 right.
  logic [PixW-1:0] win_top_r [3];
  logic [PixW-1:0] win_mid_r [3];
  logic [PixW-1:0] win_bot_r [3];
  logic [2:0]      win_cv_r;
  logic [PixW-1:0] ctr;
  logic [BinW-1:0] code;

  logic [PixW-1:0] line_rdata [NumSlots];

  // Histogram.
  logic [CodeBins-1:0] hist_vld_r;
  logic                hist_re;
  logic [BinW-1:0]     hist_raddr;
  logic [CountW-1:0]   hist_rdata;
  logic [CountW-1:0]   hist_cur;
  logic [CountW-1:0]   hist_wdata;
  logic [BinW-1:0]     rd_bin_r;

  // Result register.
  logic              out_valid_r;
  logic [CountW-1:0] out_count_r;
  logic              out_done_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= DimReset;
      cfg_rows_r <= DimReset;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_COLUMNS: cfg_cols_r <= cfg_data;
        REG_ROWS:    cfg_rows_r <= cfg_data;
        default:     cfg_cols_r <= cfg_cols_r;
      endcase
    end
  end

  always_comb begin
    if (cfg_cols_r == '0) begin
      cols_eff = ColCntW'(1);
    end else if (int'(cfg_cols_r) > MaxColumns) begin
      cols_eff = ColCntW'(MaxColumns);
    end else begin
      cols_eff = ColCntW'(cfg_cols_r);
    end
    if (cfg_rows_r == '0) begin
      rows_eff = RowCntW'(1);
    end else if (int'(cfg_rows_r) > MaxRows) begin
      rows_eff = RowCntW'(MaxRows);
    end else begin
      rows_eff = RowCntW'(cfg_rows_r);
    end
  end

  // ---------------- raster position ----------------
  assign row_end  = (ColCntW'(col_pos_r) + ColCntW'(1)) >= cols_eff;
  assign last_row = (RowCntW'(row_pos_r) + RowCntW'(1)) >= rows_eff;

  always_comb begin
    col_pos_nxt  = col_pos_r;
    row_pos_nxt  = row_pos_r;
    row_slot_nxt = row_slot_r;
    done_nxt     = done_r;
    if (cmd.clear) begin
      col_pos_nxt  = '0;
      row_pos_nxt  = '0;
      row_slot_nxt = '0;
      done_nxt     = 1'b0;
    end else if (cmd.pix_write) begin
      if (!row_end) begin
        col_pos_nxt = col_pos_r + ColW'(1);
      end else begin
        col_pos_nxt = '0;
        if (last_row) begin
          row_pos_nxt  = '0;
          row_slot_nxt = '0;
          done_nxt     = 1'b1;
        end else begin
          row_pos_nxt  = row_pos_r + RowW'(1);
          row_slot_nxt = slot_inc(row_slot_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      row_slot_r <= '0;
      done_r     <= 1'b0;
    end else begin
      col_pos_r  <= col_pos_nxt;
      row_pos_r  <= row_pos_nxt;
      row_slot_r <= row_slot_nxt;
      done_r     <= done_nxt;
    end
  end

  // Snapshot of the finished row, taken with its last pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_last_r <= 1'b0;
    end else if (cmd.pix_write && row_end) begin
      walk_last_r <= last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_write && row_end) begin
      walk_slot_r   <= row_slot_r;
      walk_above_r  <= row_pos_r != '0;
      walk_above2_r <= row_pos_r > RowW'(1);
    end
  end

  // ---------------- row walk ----------------
  assign col_in_range = walk_col_r < cols_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_final_r <= 1'b0;
      walk_col_r   <= '0;
      win_cv_r     <= '0;
    end else if (cmd.walk_start) begin
      walk_final_r <= cmd.walk_final;
      walk_col_r   <= '0;
      win_cv_r     <= '0;
    end else begin
      if (cmd.win_shift) begin
        win_cv_r <= {col_in_range, win_cv_r[2], win_cv_r[1]};
      end
      if (cmd.col_inc) begin
        walk_col_r <= walk_col_r + ColCntW'(1);
      end
    end
  end

  // Row slots of the walked row: the row above, the row itself, the row below.
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      if (cmd.walk_final) begin
        ctr_slot_r <= walk_slot_r;
        top_slot_r <= slot_inc(slot_inc(walk_slot_r));
        bot_slot_r <= slot_inc(walk_slot_r);
        top_ok_r   <= walk_above_r;
        bot_ok_r   <= 1'b0;
      end else begin
        ctr_slot_r <= slot_inc(slot_inc(walk_slot_r));
        top_slot_r <= slot_inc(walk_slot_r);
        bot_slot_r <= walk_slot_r;
        top_ok_r   <= walk_above2_r;
        bot_ok_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_shift) begin
      win_top_r[0] <= win_top_r[1];
      win_top_r[1] <= win_top_r[2];
      win_top_r[2] <= line_rdata[top_slot_r];
      win_mid_r[0] <= win_mid_r[1];
      win_mid_r[1] <= win_mid_r[2];
      win_mid_r[2] <= line_rdata[ctr_slot_r];
      win_bot_r[0] <= win_bot_r[1];
      win_bot_r[1] <= win_bot_r[2];
      win_bot_r[2] <= line_rdata[bot_slot_r];
    end
  end

  for (genvar gi = 0; gi < NumSlots; gi++) begin : g_line
    lbph_ram #(.Width(PixW), .Depth(MaxColumns)) u_line (
      .clk   (clk),
      .we    (cmd.pix_write && (row_slot_r == SlotW'(gi))),
      .waddr (col_pos_r),
      .wdata (in_pixel),
      .re    (cmd.line_rd && col_in_range),
      .raddr (walk_col_r[ColW-1:0]),
      .rdata (line_rdata[gi])
    );
  end

  // Neighbours clockwise from top-left, first one in the MSB.
  always_comb begin
    ctr     = win_mid_r[1];
    code[7] = top_ok_r & win_cv_r[0] & (win_top_r[0] >= ctr);
    code[6] = top_ok_r & (win_top_r[1] >= ctr);
    code[5] = top_ok_r & win_cv_r[2] & (win_top_r[2] >= ctr);
    code[4] = win_cv_r[2] & (win_mid_r[2] >= ctr);
    code[3] = bot_ok_r & win_cv_r[2] & (win_bot_r[2] >= ctr);
    code[2] = bot_ok_r & (win_bot_r[1] >= ctr);
    code[1] = bot_ok_r & win_cv_r[0] & (win_bot_r[0] >= ctr);
    code[0] = win_cv_r[0] & (win_mid_r[0] >= ctr);
  end

  // ---------------- histogram ----------------
  assign hist_re    = cmd.rd_issue | cmd.hist_rd;
  assign hist_raddr = cmd.rd_issue ? in_bin : code;
  assign hist_cur   = hist_vld_r[code] ? hist_rdata : '0;
  assign hist_wdata = (hist_cur == CountMax) ? hist_cur : hist_cur + CountW'(1);

  lbph_ram #(.Width(CountW), .Depth(CodeBins)) u_hist (
    .clk   (clk),
    .we    (cmd.hist_wr),
    .waddr (code),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // A bin whose valid bit is low reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      hist_vld_r <= '0;
    end else if (cmd.hist_wr) begin
      hist_vld_r[code] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_bin_r <= in_bin;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rd_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      out_count_r <= hist_vld_r[rd_bin_r] ? hist_rdata : '0;
      out_done_r  <= done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_count  = out_count_r;
  assign out_image_done = out_done_r;

  // ---------------- status ----------------
  always_comb begin
    stat.row_end    = row_end;
    stat.has_above  = row_pos_r != '0;
    stat.last_row   = last_row;
    stat.done       = done_r;
    stat.walk_last  = walk_last_r;
    stat.walk_final = walk_final_r;
    stat.col_first  = walk_col_r == '0;
    stat.col_end    = walk_col_r == cols_eff;
    stat.out_free   = !out_valid_r || out_ready;
  end

  `LBPH_CHECK(a_no_pixel_after_done, !(cmd.pix_write && done_r), "pixel stored after image done")
  `LBPH_CHECK(a_centre_valid, !(cmd.hist_rd && !win_cv_r[1]), "code counted for an empty window column")

endmodule

@@ hdl/lbp_histogram.sv @@
// Top level of the 3x3 local binary pattern histogram block.
`timescale 1ns / 1ps
// lbp_histogram takes 8-bit grey pixels in raster order on in_chan and counts the 3x3 local
// binary pattern code of every pixel into a 256-bin histogram of saturating 21-bit counts.
// Each input word carries a mode: a pixel, a read of one bin, or a clear that empties the
// histogram and restarts the image (the line store keeps its contents). Only a read gives
// an output word on out_chan, with the bin's count and a flag that is high once the whole
// image has been counted; mode 3 and pixels that arrive after the image is done are taken
// and dropped. Image width and height are set through cfg_chan (register 0 columns,
// register 1 rows, each clamped to 1..1024) and are meant to be written while the block is
// idle. The last pixel of a row starts a walk over the row above it, and the last pixel of
// the image also walks the final row; each walk does one line-store read, one window shift
// and one read-modify-write of the histogram store per column, and no input word is taken
// during a walk. A read is held in its wait state while an earlier result word is still
// held on out_chan. The histogram is valid right after reset with no clearing pass,
// because every bin has a valid bit that reset and clear drop at once.
module lbp_histogram (
  input  logic    clk,
  input  logic    rst_n,
  lbph_in_if.sink    in_chan,
  lbph_out_if.source out_chan,
  lbph_cfg_if.sink   cfg_chan
);
  import lbph_pkg::*;

  lbph_cmd_t  cmd;
  lbph_stat_t stat;

  // The sequencer owns the input handshake; all storage sits in the datapath.
  lbph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_mode  (in_chan.mode),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbph_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_pixel       (in_chan.pixel),
    .in_bin         (in_chan.bin),
    .cfg_valid      (cfg_chan.valid),
    .cfg_index      (cfg_chan.index),
    .cfg_data       (cfg_chan.data),
    .cfg_ready      (cfg_chan.ready),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_bin_count  (out_chan.bin_count),
    .out_image_done (out_chan.image_done)
  );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the LBP histogram block: random images, reads and clears.
`timescale 1ns / 1ps
module tb_top;
  import lbph_pkg::*;

  // Mode 3 has no member in the package enum; the block takes such a word and drops it.
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam int MaxGap      = 11;
  localparam int ResetCycles = 11;
  localparam int WordBudget  = 1870;
  localparam int CycleLimit  = 1_000_000;

  // One expected read result: the count of the requested bin and the image-done flag.
  typedef struct packed {
    logic [CountW-1:0] bin_count;
    logic              image_done;
  } bin_read_t;

  // Tracks the image the block should be building and the read results it owes us.
  // Every accepted input word is applied here in order; each read pushes the result that
  // the block must return for it.
  class pattern_histogram;
    logic [PixW-1:0]   line_rows [NumSlots*MaxColumns];
    logic [CountW-1:0] bin_counts [CodeBins];
    int unsigned       next_col, next_row;
    bit                all_counted;
    logic [DimW-1:0]   columns_reg, rows_reg;
    int                ring_dx [8];
    int                ring_dy [8];
    bin_read_t         expected_reads [$];
    int unsigned       failures;

    function new();
      foreach (line_rows[i]) line_rows[i] = '0;
      // Neighbors clockwise from the top-left; the first one lands in code bit 7.
      ring_dx = '{-1, 0, 1, 1, 1, 0, -1, -1};
      ring_dy = '{-1, -1, -1, 0, 1, 1, 1, 0};
      columns_reg = DimReset;
      rows_reg = DimReset;
      failures = 0;
      restart_image();
    endfunction

    // A clear empties the histogram and restarts the raster; the line rows are kept.
    function void restart_image();
      foreach (bin_counts[i]) bin_counts[i] = '0;
      next_col = 0;
      next_row = 0;
      all_counted = 1'b0;
    endfunction

    function int unsigned bounded_dim(logic [DimW-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int unsigned columns_used();
      return bounded_dim(columns_reg, MaxColumns);
    endfunction

    function int unsigned rows_used();
      return bounded_dim(rows_reg, MaxRows);
    endfunction

    function void set_register(reg_idx_t idx, logic [DimW-1:0] val);
      case (idx)
        REG_COLUMNS: columns_reg = val;
        REG_ROWS:    rows_reg = val;
        default: ;
      endcase
    endfunction

    function logic [PixW-1:0] stored_pixel(int unsigned ry, int unsigned x);
      return line_rows[(ry % NumSlots) * MaxColumns + x];
    endfunction

    // Pattern code of one pixel; neighbors outside the image contribute a zero bit.
    function logic [7:0] pattern_code(int unsigned cy, int unsigned cx, int unsigned cols,
                                      int unsigned bottom);
      logic [PixW-1:0] center;
      logic [7:0]      code;
      int              nx, ny;
      center = stored_pixel(cy, cx);
      code = '0;
      for (int k = 0; k < 8; k++) begin
        nx = int'(cx) + ring_dx[k];
        ny = int'(cy) + ring_dy[k];
        if (nx >= 0 && nx < int'(cols) && ny >= 0 && ny <= int'(bottom) &&
            stored_pixel(ny, nx) >= center)
          code[7-k] = 1'b1;
      end
      return code;
    endfunction

    function void tally_row(int unsigned cy, int unsigned cols, int unsigned bottom);
      logic [7:0] code;
      for (int unsigned x = 0; x < cols; x++) begin
        code = pattern_code(cy, x, cols, bottom);
        if (bin_counts[code] != CountMax) bin_counts[code]++;
      end
    endfunction

    // Applies one accepted input word.
    function void take_word(logic [ModeW-1:0] mode, logic [PixW-1:0] px,
                            logic [BinW-1:0] bin);
      int unsigned cols, rows;
      cols = columns_used();
      rows = rows_used();
      case (mode)
        MODE_PIXEL: begin
          // Pixels that arrive after the image is complete are dropped until a clear.
          if (!all_counted) begin
            line_rows[(next_row % NumSlots) * MaxColumns + next_col] = px;
            if (next_col + 1 < cols) begin
              next_col++;
            end else begin
              // The row is complete, so the row above it now has all its neighbors.
              next_col = 0;
              if (next_row >= 1) tally_row(next_row - 1, cols, next_row);
              if (next_row + 1 >= rows) begin
                tally_row(next_row, cols, next_row);
                all_counted = 1'b1;
                next_row = 0;
              end else begin
                next_row++;
              end
            end
          end
        end
        MODE_READ: begin
          expected_reads.push_back('{bin_count: bin_counts[bin], image_done: all_counted});
        end
        MODE_CLEAR: restart_image();
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_reads.size();
    endfunction

    // Compares one accepted result word with the oldest outstanding read.
    function void check_read(logic [CountW-1:0] count, logic done);
      bin_read_t want;
      if (expected_reads.size() == 0) begin
        $error("result word with no read outstanding: bin_count %0d image_done %0b",
               count, done);
        failures++;
        return;
      end
      want = expected_reads.pop_front();
      if (count !== want.bin_count) begin
        $error("bin_count: expected %0d, actual %0d", want.bin_count, count);
        failures++;
      end
      if (done !== want.image_done) begin
        $error("image_done: expected %0b, actual %0b", want.image_done, done);
        failures++;
      end
    endfunction

    // A bin that currently holds a count, so reads mostly hit something interesting.
    function logic [BinW-1:0] filled_bin();
      logic [BinW-1:0] hits [$];
      for (int b = 0; b < CodeBins; b++)
        if (bin_counts[b] != 0) hits.push_back(BinW'(b));
      if (hits.size() == 0) return BinW'($urandom_range(0, CodeBins - 1));
      return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    // The last pixel of an image can start two row walks back to back.
    function int unsigned walk_cycles();
      return 2 * (4 * columns_used() + 3) + 16;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  bit          steady;
  int unsigned words_sent;

  pattern_histogram board = new();

  lbph_in_if  in_if ();
  lbph_out_if out_if ();
  lbph_cfg_if cfg_if ();

  lbp_histogram DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("tb_top failed");
    $finish;
  end

  // Idle cycles before a word; zero throughout a steady stretch.
  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Drives one input word. Inputs change on the falling edge and the handshake is sampled
  // on the rising edge. Valid stays high from the previous word when no gap is drawn, so a
  // back-to-back word only changes the payload.
  task automatic send_word(logic [ModeW-1:0] mode, logic [PixW-1:0] px,
                           logic [BinW-1:0] bin);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.pixel <= px;
    in_if.bin   <= bin;
    do @(posedge clk); while (!in_if.ready);
    board.take_word(mode, px, bin);
    if (mode != ModeUnused) words_sent++;
  endtask

  task automatic read_bin();
    logic [BinW-1:0] bin;
    bin = ($urandom_range(0, 2) != 0) ? board.filled_bin() : BinW'($urandom);
    send_word(MODE_READ, PixW'($urandom), bin);
  endtask

  // Register writes happen only while the input channel is quiet.
  task automatic write_reg(reg_idx_t idx, logic [DimW-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_register(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Drops valid, waits for every outstanding read, then lets any row walk finish. A walk
  // gives no result word, so the drained queue alone does not prove the block is idle.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (board.walk_cycles()) @(posedge clk);
  endtask

  // One image: a clear, then the pixels in raster order with reads sprinkled in. The noisy
  // form also drops in mode 3 words, sometimes restarts the image halfway with a clear and
  // sometimes sends pixels after the image is done, which the block must ignore.
  task automatic run_image(int unsigned limit, bit noisy);
    int unsigned     total, style, cut;
    logic [PixW-1:0] base, px;
    total = board.columns_used() * board.rows_used();
    if (total > limit) total = limit;
    style = $urandom_range(0, 3);
    base = PixW'($urandom);
    cut = (noisy && $urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
    steady = ($urandom_range(0, 3) == 0);
    send_word(MODE_CLEAR, PixW'($urandom), BinW'($urandom));
    for (int unsigned p = 0; p < total; p++) begin
      if (p == cut) send_word(MODE_CLEAR, PixW'($urandom), BinW'($urandom));
      // Narrow and flat images make neighbors equal to the center, which sets the bit.
      case (style)
        0:       px = PixW'($urandom);
        1:       px = PixW'(base + $urandom_range(0, 3));
        2:       px = base;
        default: px = ($urandom_range(0, 1) != 0) ? '1 : '0;
      endcase
      send_word(MODE_PIXEL, px, BinW'($urandom));
      if ($urandom_range(0, 7) == 0) read_bin();
      if (noisy && $urandom_range(0, 39) == 0)
        send_word(ModeUnused, PixW'($urandom), BinW'($urandom));
    end
    repeat ($urandom_range(1, 3)) read_bin();
    if (noisy && $urandom_range(0, 3) == 0) begin
      send_word(MODE_PIXEL, PixW'($urandom), BinW'($urandom));
      read_bin();
    end
  endtask

  // Result side: draws a stall for every word, holds ready high once it is over and checks
  // the word on the edge that accepts it.
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      board.check_read(out_if.bin_count, out_if.image_done);
    end
  end

  initial begin : stimulus
    logic [DimW-1:0] cols_val, rows_val;
    int unsigned     phase, limit;
    rst_n        = 1'b0;
    steady       = 1'b0;
    words_sent   = 0;
    in_if.valid  = 1'b0;
    in_if.mode   = MODE_PIXEL;
    in_if.pixel  = '0;
    in_if.bin    = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_COLUMNS;
    cfg_if.data  = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Reads straight out of reset must see empty bins with no clearing
    // pass, and a mode 3 word must give nothing back.
    send_word(MODE_READ, 8'h00, 8'h00);
    send_word(MODE_READ, 8'hFF, 8'hFF);
    send_word(ModeUnused, 8'hFF, 8'hFF);
    send_word(MODE_PIXEL, 8'hA5, 8'h00);
    send_word(MODE_CLEAR, 8'h00, 8'h00);
    settle();
    write_reg(REG_COLUMNS, DimW'(3));
    write_reg(REG_ROWS, DimW'(2));
    // A 3x2 image with both pixel extremes and a run of equal values, so that ties with
    // the center and out-of-image neighbors both shape the codes.
    send_word(MODE_CLEAR, 8'h00, 8'h00);
    send_word(MODE_PIXEL, 8'h00, 8'h00);
    send_word(MODE_PIXEL, 8'hFF, 8'hFF);
    send_word(MODE_PIXEL, 8'h07, 8'h00);
    send_word(MODE_PIXEL, 8'h07, 8'hFF);
    send_word(MODE_PIXEL, 8'h07, 8'h00);
    send_word(MODE_PIXEL, 8'hC8, 8'h00);
    send_word(MODE_READ, 8'h00, board.filled_bin());
    send_word(MODE_READ, 8'hFF, board.filled_bin());
    send_word(MODE_READ, 8'h00, 8'hFF);
    // The image is done, so this pixel must be dropped without touching the counts.
    send_word(MODE_PIXEL, 8'h00, 8'h00);
    send_word(MODE_READ, 8'h00, 8'h00);
    send_word(MODE_CLEAR, 8'hFF, 8'hFF);
    send_word(MODE_READ, 8'h00, 8'h00);

    // Random part, one register setting per phase. The first phases take the extremes:
    // the widest image as a single row run to completion, a single column down the
    // tallest image, a zero column count and an all-ones row count that clamps.
    // Large images are cut short except the first; later phases use small images.
    phase = 0;
    while (words_sent < WordBudget) begin
      limit = MaxColumns * MaxRows;
      case (phase)
        0: begin
          cols_val = 11'd2047;
          rows_val = 11'd0;
        end
        1: begin
          cols_val = 11'd1;
          rows_val = 11'd1024;
          limit = 80;
        end
        2: begin
          cols_val = 11'd0;
          rows_val = 11'd1;
        end
        3: begin
          cols_val = 11'd1024;
          rows_val = 11'd2047;
          limit = 30;
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       cols_val = DimW'($urandom_range(1, 3));
            1:       cols_val = DimW'($urandom_range(13, 40));
            default: cols_val = DimW'($urandom_range(2, 12));
          endcase
          rows_val = DimW'($urandom_range(1, 8));
        end
      endcase
      settle();
      write_reg(REG_COLUMNS, cols_val);
      write_reg(REG_ROWS, rows_val);
      repeat ((phase == 0) ? 1 : $urandom_range(1, 3)) run_image(limit, phase != 0);
      phase++;
    end

    settle();
    if (board.failures == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
